// ===== rtl/assert_macros.svh =====
// assertion macros used by the core rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// condition that must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/rlbs_pkg.sv =====
// types and constants of the random led breathe scheduler
package rlbs_pkg;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_RISE = 2'd1,
        PH_HOLD = 2'd2,
        PH_FALL = 2'd3
    } phase_t;

    typedef struct packed {
        phase_t      phase;
        logic [15:0] hold;
    } slot_t;

    // configuration register indexes
    localparam logic [2:0] CFG_SLOTS_IN_USE = 3'd0;
    localparam logic [2:0] CFG_MAX_LIT      = 3'd1;
    localparam logic [2:0] CFG_RISE_TIME    = 3'd2;
    localparam logic [2:0] CFG_DWELL_TIME   = 3'd3;
    localparam logic [2:0] CFG_DECAY_TIME   = 3'd4;
    localparam logic [2:0] CFG_PEAK_LEVEL   = 3'd5;
    localparam logic [2:0] CFG_NOISE_SEED   = 3'd6;

    localparam logic [31:0] LFSR_TAPS = 32'h8020_0003;
    localparam logic [9:0]  HUE_RANGE = 10'd1000;

    // one step of the galois lfsr
    function automatic logic [31:0] lfsr_step(input logic [31:0] v);
        lfsr_step = {1'b0, v[31:1]} ^ (v[0] ? LFSR_TAPS : 32'd0);
    endfunction

endpackage

// ===== rtl/rlbs_cell.sv =====
// one slot cell of the rotating slot ring
module rlbs_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            shift,
    input  rlbs_pkg::slot_t d,
    output rlbs_pkg::slot_t q
);
    import rlbs_pkg::*;

    slot_t slot_reg;

    // take the neighbour's slot on every shift
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '{phase: PH_IDLE, hold: 16'd0};
        end
        else if (shift)
        begin
            slot_reg <= d;
        end
    end

    assign q = slot_reg;

endmodule

// ===== rtl/rlbs_div.sv =====
// bit-serial restoring divider giving the remainder of a 32-bit value by a small divisor
module rlbs_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [9:0]  divisor,
    output logic        done,
    output logic [9:0]  rem
);
    logic        run_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [31:0] a_reg;
    logic [9:0]  r_reg;
    logic [9:0]  b_reg;
    logic [10:0] trial;
    logic        ge;

    // one quotient bit per cycle
    assign trial = {r_reg, a_reg[31]};
    assign ge    = trial >= {1'b0, b_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= 5'd0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= dividend;
            r_reg <= 10'd0;
            b_reg <= divisor;
        end
        else if (run_reg)
        begin
            a_reg <= {a_reg[30:0], ge};
            r_reg <= ge ? 10'(trial - {1'b0, b_reg}) : trial[9:0];
        end
    end

    assign done = done_reg;
    assign rem  = r_reg;

endmodule

// ===== rtl/random_led_breathe_scheduler_core.sv =====
// top level of the random led breathe scheduler: slot ring, sequencer and output stage
//
// channel   | direction | tdata fields (low bit up)                       | flag
// s_axis    | in        | elapsed_ms, fade_busy_mask                      | -
// m_axis    | out       | slot_number, red, green, blue, fade_time_ms     | tlast = final_command
// cfg       | in        | write enable, index, data                       | -
//
// a tick rotates the ring once round for the hold and mask scan and then passes a check state;
// each random pick draws a value, waits for the serial remainder and rotates the ring once round;
// a started slot then takes its colour through S_COLOR to S_RAMP (S_COLOR alone with zero peak).
// the start command is queued in S_EMIT and the last command is handed over in S_FIN.
// the scan, the start and the last command stall while the output register is full.
// reset clears every slot to inactive, registers to their defaults, lfsr to 1.
`include "assert_macros.svh"
module random_led_breathe_scheduler_core #(
    parameter int SLOTS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // elapsed_ms[15:0], fade_busy_mask[47:16]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // slot_number[4:0], red_level[12:5], green_level[20:13], blue_level[28:21],
    // fade_time_ms[44:29], zero fill[47:45]
    output logic [47:0] m_axis_tdata,
    output logic        m_axis_tlast,  // final_command
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import rlbs_pkg::*;

    localparam int CW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [CW-1:0] LAST = CW'(SLOTS - 1);
    // 2^16 mod 1000, folds the upper half of a draw onto the lower
    localparam logic [9:0]  HUE_FOLD   = 10'd536;
    // ceil(2^36 / 1000), exact quotient for folded values below 2^26
    localparam logic [26:0] HUE_RECIP  = 27'd68719477;
    // ceil(2^28 / 1000), exact quotient for ramp products below 2^18
    localparam logic [18:0] RAMP_RECIP = 19'd268436;

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_CHECK, S_DRAW, S_WPICK, S_ROT,
        S_COLOR, S_FOLD, S_HUEQ, S_HUE, S_SECT, S_RAMP, S_EMIT, S_FIN
    } state_t;

    typedef struct packed {
        logic [15:0] fade;
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
        logic [4:0]  slot;
    } result_t;

    state_t      state_reg;
    logic [5:0]  slots_reg, maxlit_reg;
    logic [15:0] rise_reg, dwell_reg, decay_reg;
    logic [7:0]  peak_reg;
    logic [31:0] lfsr_reg;
    logic [15:0] step_reg;
    logic [SLOTS-1:0] mask_reg;
    logic [5:0]  n_reg, busy_reg, tries_reg;
    logic [CW-1:0] cnt_reg;
    logic [4:0]  idx_reg;
    logic        found_reg;
    logic [25:0] fold_reg;
    logic [16:0] hue_q_reg;
    logic [9:0]  hue_reg;
    logic [2:0]  sector_reg;
    logic [17:0] prod_reg;
    logic [7:0]  ramp_reg;
    logic        pend_valid_reg;
    result_t     pend_reg;
    logic        out_valid_reg;
    logic        out_last_reg;
    result_t     out_reg;
    logic        div_start_reg;
    logic [31:0] div_a_reg;
    logic [9:0]  div_b_reg;

    slot_t       ring_q [SLOTS];
    slot_t       tail_in;
    slot_t       scan_val, rot_val, head;
    logic        shift_en, emit, out_free, managed;
    logic        div_done;
    logic [9:0]  div_rem;
    logic [31:0] lfsr_nxt;
    logic [5:0]  lit;
    logic [12:0] h6;
    logic [2:0]  sect;
    logic [12:0] sect_base;
    logic [9:0]  rem6, tval;
    logic [52:0] hue_prod;
    logic [36:0] ramp_prod;
    result_t     dark_res, start_res;

    // slot ring: each cell hands its slot towards the head
    genvar gi;
    generate
        for (gi = 0; gi < SLOTS; gi++)
        begin : g_cell
            slot_t d_in;
            if (gi == SLOTS - 1)
            begin : g_tail
                assign d_in = tail_in;
            end
            else
            begin : g_mid
                assign d_in = ring_q[gi+1];
            end
            rlbs_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .shift (shift_en),
                .d     (d_in),
                .q     (ring_q[gi])
            );
        end
    endgenerate

    rlbs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (div_a_reg),
        .divisor  (div_b_reg),
        .done     (div_done),
        .rem      (div_rem)
    );

    assign head     = ring_q[0];
    assign out_free = !out_valid_reg || m_axis_tready;
    assign lfsr_nxt = lfsr_step(lfsr_reg);
    assign lit      = (maxlit_reg > n_reg) ? n_reg : maxlit_reg;
    assign managed  = 6'(cnt_reg) < n_reg;

    // reciprocal products for the hue remainder and the ramp quotient
    assign hue_prod  = 53'(fold_reg) * 53'(HUE_RECIP);
    assign ramp_prod = 37'(prod_reg) * 37'(RAMP_RECIP);

    // hold count down and busy mask for the slot at the head
    always_comb
    begin
        scan_val = head;
        emit     = 1'b0;
        if (managed)
        begin
            if (head.phase == PH_HOLD)
            begin
                if (head.hold > step_reg)
                begin
                    scan_val.hold = head.hold - step_reg;
                end
                else
                begin
                    scan_val.hold  = 16'd0;
                    scan_val.phase = PH_FALL;
                    emit           = 1'b1;
                end
            end
            if (scan_val.phase == PH_RISE && !mask_reg[cnt_reg])
            begin
                scan_val.phase = PH_HOLD;
                scan_val.hold  = dwell_reg;
            end
            else if (scan_val.phase == PH_FALL && !mask_reg[cnt_reg] && !emit)
            begin
                scan_val.phase = PH_IDLE;
            end
        end
    end

    // start of the picked slot as it passes the head
    always_comb
    begin
        rot_val = head;
        if (6'(cnt_reg) == 6'(idx_reg) && head.phase == PH_IDLE)
        begin
            rot_val.phase = PH_RISE;
            rot_val.hold  = dwell_reg;
        end
    end

    // ring feed and shift
    always_comb
    begin
        tail_in  = head;
        shift_en = 1'b0;
        if (state_reg == S_SCAN)
        begin
            tail_in  = scan_val;
            shift_en = !(emit && pend_valid_reg && !out_free);
        end
        else if (state_reg == S_ROT)
        begin
            tail_in  = rot_val;
            shift_en = 1'b1;
        end
    end

    // hue sector and ramp position
    always_comb
    begin
        h6 = 13'(hue_reg) * 13'd6;
        if (h6 >= 13'd5000)
        begin
            sect = 3'd5;
        end
        else if (h6 >= 13'd4000)
        begin
            sect = 3'd4;
        end
        else if (h6 >= 13'd3000)
        begin
            sect = 3'd3;
        end
        else if (h6 >= 13'd2000)
        begin
            sect = 3'd2;
        end
        else if (h6 >= 13'd1000)
        begin
            sect = 3'd1;
        end
        else
        begin
            sect = 3'd0;
        end
        sect_base = 13'(sect) * 13'(HUE_RANGE);
        rem6      = 10'(h6 - sect_base);
        tval      = sect[0] ? (HUE_RANGE - rem6) : rem6;
    end

    // command words
    always_comb
    begin
        dark_res       = '0;
        dark_res.slot  = 5'(cnt_reg);
        dark_res.fade  = decay_reg;
        start_res      = '0;
        start_res.slot = idx_reg;
        start_res.fade = rise_reg;
        case (sector_reg)
            3'd0:    begin start_res.red   = peak_reg; start_res.green = ramp_reg; end
            3'd1:    begin start_res.red   = ramp_reg; start_res.green = peak_reg; end
            3'd2:    begin start_res.green = peak_reg; start_res.blue  = ramp_reg; end
            3'd3:    begin start_res.green = ramp_reg; start_res.blue  = peak_reg; end
            3'd4:    begin start_res.red   = ramp_reg; start_res.blue  = peak_reg; end
            default: begin start_res.red   = peak_reg; start_res.blue  = ramp_reg; end
        endcase
    end

    // sequencer, configuration and output stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            slots_reg      <= 6'd32;
            maxlit_reg     <= 6'd4;
            rise_reg       <= 16'd500;
            dwell_reg      <= 16'd500;
            decay_reg      <= 16'd500;
            peak_reg       <= 8'd255;
            lfsr_reg       <= 32'd1;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            div_start_reg  <= 1'b0;
            cnt_reg        <= '0;
            busy_reg       <= 6'd0;
            tries_reg      <= 6'd0;
            found_reg      <= 1'b0;
        end
        else
        begin
            div_start_reg <= 1'b0;
            if (out_valid_reg && m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_SLOTS_IN_USE: slots_reg  <= cfg_data[5:0];
                    CFG_MAX_LIT:      maxlit_reg <= cfg_data[5:0];
                    CFG_RISE_TIME:    rise_reg   <= cfg_data[15:0];
                    CFG_DWELL_TIME:   dwell_reg  <= cfg_data[15:0];
                    CFG_DECAY_TIME:   decay_reg  <= cfg_data[15:0];
                    CFG_PEAK_LEVEL:   peak_reg   <= cfg_data[7:0];
                    CFG_NOISE_SEED:   lfsr_reg   <= (cfg_data != 32'd0) ? cfg_data : 32'd1;
                    default:          ;
                endcase
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        step_reg <= s_axis_tdata[15:0];
                        mask_reg <= s_axis_tdata[16 +: SLOTS];
                        n_reg    <= (slots_reg > 6'(SLOTS)) ? 6'(SLOTS) : slots_reg;
                        cnt_reg  <= '0;
                        busy_reg <= 6'd0;
                        if (slots_reg != 6'd0)
                        begin
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_SCAN:
                begin
                    if (shift_en)
                    begin
                        if (emit)
                        begin
                            if (pend_valid_reg)
                            begin
                                out_reg       <= pend_reg;
                                out_last_reg  <= 1'b0;
                                out_valid_reg <= 1'b1;
                            end
                            pend_reg       <= dark_res;
                            pend_valid_reg <= 1'b1;
                        end
                        if (managed && scan_val.phase != PH_IDLE)
                        begin
                            busy_reg <= busy_reg + 6'd1;
                        end
                        if (cnt_reg == LAST)
                        begin
                            cnt_reg   <= '0;
                            state_reg <= S_CHECK;
                        end
                        else
                        begin
                            cnt_reg <= cnt_reg + CW'(1);
                        end
                    end
                end
                S_CHECK:
                begin
                    tries_reg <= 6'd0;
                    found_reg <= 1'b0;
                    state_reg <= (lit != 6'd0 && busy_reg < lit) ? S_DRAW : S_FIN;
                end
                S_DRAW:
                begin
                    lfsr_reg      <= lfsr_nxt;
                    div_a_reg     <= lfsr_nxt;
                    div_b_reg     <= 10'(n_reg);
                    div_start_reg <= 1'b1;
                    state_reg     <= S_WPICK;
                end
                S_WPICK:
                begin
                    if (div_done)
                    begin
                        idx_reg   <= div_rem[4:0];
                        cnt_reg   <= '0;
                        state_reg <= S_ROT;
                    end
                end
                S_ROT:
                begin
                    if (6'(cnt_reg) == 6'(idx_reg) && head.phase == PH_IDLE)
                    begin
                        found_reg <= 1'b1;
                    end
                    if (cnt_reg == LAST)
                    begin
                        cnt_reg <= '0;
                        if (found_reg || (6'(cnt_reg) == 6'(idx_reg) && head.phase == PH_IDLE))
                        begin
                            state_reg <= S_COLOR;
                        end
                        else if (tries_reg + 6'd1 == n_reg)
                        begin
                            state_reg <= S_FIN;
                        end
                        else
                        begin
                            tries_reg <= tries_reg + 6'd1;
                            state_reg <= S_DRAW;
                        end
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + CW'(1);
                    end
                end
                S_COLOR:
                begin
                    if (peak_reg == 8'd0)
                    begin
                        sector_reg <= 3'd0;
                        ramp_reg   <= 8'd0;
                        state_reg  <= S_EMIT;
                    end
                    else
                    begin
                        lfsr_reg  <= lfsr_nxt;
                        state_reg <= S_FOLD;
                    end
                end
                S_FOLD:
                begin
                    fold_reg  <= 26'(lfsr_reg[31:16]) * 26'(HUE_FOLD) + 26'(lfsr_reg[15:0]);
                    state_reg <= S_HUEQ;
                end
                S_HUEQ:
                begin
                    hue_q_reg <= hue_prod[52:36];
                    state_reg <= S_HUE;
                end
                S_HUE:
                begin
                    hue_reg   <= 10'(fold_reg - 26'(hue_q_reg) * 26'(HUE_RANGE));
                    state_reg <= S_SECT;
                end
                S_SECT:
                begin
                    sector_reg <= sect;
                    prod_reg   <= 18'(peak_reg) * 18'(tval) + 18'd500;
                    state_reg  <= S_RAMP;
                end
                S_RAMP:
                begin
                    ramp_reg  <= ramp_prod[35:28];
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (!pend_valid_reg)
                    begin
                        pend_reg       <= start_res;
                        pend_valid_reg <= 1'b1;
                        state_reg      <= S_FIN;
                    end
                    else if (out_free)
                    begin
                        out_reg        <= pend_reg;
                        out_last_reg   <= 1'b0;
                        out_valid_reg  <= 1'b1;
                        pend_reg       <= start_res;
                        state_reg      <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    if (!pend_valid_reg)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else if (out_free)
                    begin
                        out_reg        <= pend_reg;
                        out_last_reg   <= 1'b1;
                        out_valid_reg  <= 1'b1;
                        pend_valid_reg <= 1'b0;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_reg};
    assign m_axis_tlast  = out_last_reg;

    // checks
    `ASSERT_IMPL(a_idle_no_pending, clk, rst_n, s_axis_tready, !pend_valid_reg, "pending at idle")
    `ASSERT_IMPL(a_div_done_waited, clk, rst_n, div_done, state_reg == S_WPICK, "stray divider result")
    `ASSERT_NEVER(a_ring_aligned, clk, rst_n, (state_reg == S_IDLE && cnt_reg != '0), "ring misaligned")

endmodule

// ===== test/random_led_breathe_scheduler_core_tb.sv =====
// testbench of the random led breathe scheduler: predicts fade commands per tick and checks them
module random_led_breathe_scheduler_core_tb;
    import rlbs_pkg::*;

    // one expected fade command
    typedef struct {
        logic [4:0]  slot;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [15:0] fade_ms;
        logic        last;
    } fade_cmd_t;

    // predicted slot state and the queue of commands still to come
    class breathe_ledger;
        logic [5:0]  slots_in_use = 6'd32;
        logic [5:0]  max_lit = 6'd4;
        logic [15:0] rise_ms = 16'd500;
        logic [15:0] dwell_ms = 16'd500;
        logic [15:0] decay_ms = 16'd500;
        logic [7:0]  peak = 8'd255;
        logic [31:0] noise = 32'd1;
        phase_t      phase [32];
        logic [15:0] hold_ms [32];
        fade_cmd_t   pending_cmds [$];
        int          mismatches = 0;

        function new();
            foreach (phase[i])
            begin
                phase[i] = PH_IDLE;
                hold_ms[i] = '0;
            end
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                CFG_SLOTS_IN_USE: slots_in_use = val[5:0];
                CFG_MAX_LIT:      max_lit = val[5:0];
                CFG_RISE_TIME:    rise_ms = val[15:0];
                CFG_DWELL_TIME:   dwell_ms = val[15:0];
                CFG_DECAY_TIME:   decay_ms = val[15:0];
                CFG_PEAK_LEVEL:   peak = val[7:0];
                CFG_NOISE_SEED:   noise = (val == 0) ? 32'd1 : val;
                default: ;
            endcase
        endfunction

        // galois shift, taps at bits 31, 21, 1, 0
        function logic [31:0] next_noise();
            logic out_bit;
            out_bit = noise[0];
            noise = noise >> 1;
            if (out_bit)
                noise = noise ^ 32'h8020_0003;
            return noise;
        endfunction

        // full-saturation colour for one hue draw
        function void hue_colour(output logic [7:0] r, output logic [7:0] g,
                                 output logic [7:0] b);
            int unsigned hue, sector, rem_part, frac, ramp;
            r = '0;
            g = '0;
            b = '0;
            if (peak == 0)
                return;
            hue = next_noise() % 1000;
            sector = (hue * 6) / 1000;
            rem_part = hue * 6 - sector * 1000;
            frac = sector[0] ? 1000 - rem_part : rem_part;
            ramp = (peak * frac + 500) / 1000;
            case (sector)
                0: begin r = peak; g = 8'(ramp); end
                1: begin r = 8'(ramp); g = peak; end
                2: begin g = peak; b = 8'(ramp); end
                3: begin g = 8'(ramp); b = peak; end
                4: begin r = 8'(ramp); b = peak; end
                default: begin r = peak; b = 8'(ramp); end
            endcase
        endfunction

        // advance all managed slots by one tick
        function void note_tick(logic [15:0] elapsed, logic [31:0] busy_mask);
            int unsigned n, lit, busy, idx;
            bit          fresh [32];
            fade_cmd_t   cmds [$];
            fade_cmd_t   c;
            n = (slots_in_use > 32) ? 32 : slots_in_use;
            if (n == 0)
                return;
            foreach (fresh[i])
                fresh[i] = 0;
            // hold countdown, expired slots go dark
            for (int i = 0; i < n; i++)
            begin
                if (phase[i] != PH_HOLD)
                    continue;
                if (hold_ms[i] > elapsed)
                    hold_ms[i] = hold_ms[i] - elapsed;
                else
                begin
                    hold_ms[i] = '0;
                    phase[i] = PH_FALL;
                    fresh[i] = 1;
                    c = '{slot: 5'(i), red: 8'd0, green: 8'd0, blue: 8'd0,
                          fade_ms: decay_ms, last: 1'b0};
                    cmds.push_back(c);
                end
            end
            // finished external fades
            for (int i = 0; i < n; i++)
            begin
                if (phase[i] == PH_RISE && !busy_mask[i])
                begin
                    phase[i] = PH_HOLD;
                    hold_ms[i] = dwell_ms;
                end
                else if (phase[i] == PH_FALL && !busy_mask[i] && !fresh[i])
                    phase[i] = PH_IDLE;
            end
            // random start of one idle slot
            lit = (max_lit > n) ? n : max_lit;
            if (lit != 0)
            begin
                busy = 0;
                for (int i = 0; i < n; i++)
                    if (phase[i] != PH_IDLE)
                        busy++;
                if (busy < lit)
                begin
                    for (int t = 0; t < n; t++)
                    begin
                        idx = next_noise() % n;
                        if (phase[idx] == PH_IDLE)
                        begin
                            hue_colour(c.red, c.green, c.blue);
                            c.slot = 5'(idx);
                            c.fade_ms = rise_ms;
                            c.last = 0;
                            phase[idx] = PH_RISE;
                            hold_ms[idx] = dwell_ms;
                            cmds.push_back(c);
                            break;
                        end
                    end
                end
            end
            if (cmds.size() > 0)
                cmds[cmds.size() - 1].last = 1;
            foreach (cmds[i])
                pending_cmds.push_back(cmds[i]);
        endfunction

        function void check_command(logic [47:0] data, logic last);
            fade_cmd_t exp_cmd;
            if (pending_cmds.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected command: data %h last %b", data, last);
                return;
            end
            exp_cmd = pending_cmds.pop_front();
            if (data[4:0] !== exp_cmd.slot || data[12:5] !== exp_cmd.red
                || data[20:13] !== exp_cmd.green || data[28:21] !== exp_cmd.blue
                || data[44:29] !== exp_cmd.fade_ms || data[47:45] !== 3'd0
                || last !== exp_cmd.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("command mismatch: exp slot %0d rgb %0d/%0d/%0d ms %0d last %b,",
                             exp_cmd.slot, exp_cmd.red, exp_cmd.green, exp_cmd.blue,
                             exp_cmd.fade_ms, exp_cmd.last,
                             " got slot %0d rgb %0d/%0d/%0d ms %0d last %b fill %0d",
                             data[4:0], data[12:5], data[20:13], data[28:21],
                             data[44:29], last, data[47:45]);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    breathe_ledger ledger = new();
    int  burst_left = 0;
    bit  want_holdoff = 0;

    random_led_breathe_scheduler_core dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // clock
    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    // overall time limit
    initial
    begin
        #80_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // receiver stall pattern, with a long hold-off on request
    initial
    begin
        int hold_cnt;
        int mode_left;
        int mode;
        hold_cnt = 0;
        mode_left = 0;
        mode = 0;
        m_axis_tready = 0;
        forever
        begin
            @(posedge clk);
            if (want_holdoff && hold_cnt == 0)
            begin
                want_holdoff = 0;
                hold_cnt = 3000;
            end
            if (mode_left == 0)
            begin
                mode = $urandom_range(0, 2);
                mode_left = $urandom_range(20, 300);
            end
            mode_left--;
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                m_axis_tready <= 0;
            end
            else if (mode == 0)
                m_axis_tready <= 1;
            else if (mode == 1)
                m_axis_tready <= ($urandom_range(0, 9) < 7);
            else
                m_axis_tready <= ($urandom_range(0, 9) < 2);
        end
    end

    // output monitor
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            ledger.check_command(m_axis_tdata, m_axis_tlast);
    end

    // register write; the enable is lowered by end_writes
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        ledger.write_reg(idx, val);
        @(posedge clk);
    endtask

    task automatic end_writes();
        cfg_we <= 0;
        @(posedge clk);
    endtask

    // one tick transaction, in bursts with random gaps
    task automatic send_tick(input logic [15:0] elapsed, input logic [31:0] busy_mask);
        s_axis_tvalid <= 1;
        s_axis_tdata <= {busy_mask, elapsed};
        do
            @(posedge clk);
        while (!s_axis_tready);
        ledger.note_tick(elapsed, busy_mask);
        if (burst_left == 0)
        begin
            s_axis_tvalid <= 0;
            repeat ($urandom_range(1, 25)) @(posedge clk);
            burst_left = $urandom_range(1, 12);
        end
        else
            burst_left--;
    endtask

    task automatic random_ticks(input int count);
        logic [15:0] elapsed;
        logic [31:0] busy_mask;
        for (int k = 0; k < count; k++)
        begin
            case ($urandom_range(0, 9))
                0: elapsed = 16'd0;
                1: elapsed = 16'hFFFF;
                2, 3, 4, 5: elapsed = 16'($urandom_range(0, 300));
                default: elapsed = 16'($urandom_range(0, 2000));
            endcase
            // mostly finished fades so slots keep cycling
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: busy_mask = 0;
                5, 6: busy_mask = $urandom;
                7: busy_mask = '1;
                default: busy_mask = $urandom & $urandom;
            endcase
            send_tick(elapsed, busy_mask);
        end
    endtask

    // wait until every command has come and the block has gone quiet
    task automatic drain();
        s_axis_tvalid <= 0;
        @(posedge clk);
        while (ledger.pending_cmds.size() != 0)
            @(posedge clk);
        repeat (2600) @(posedge clk);
    endtask

    task automatic random_setting();
        write_reg(CFG_SLOTS_IN_USE, $urandom_range(1, 32));
        write_reg(CFG_MAX_LIT, $urandom_range(0, 40));
        write_reg(CFG_RISE_TIME, $urandom & 16'hFFFF);
        write_reg(CFG_DWELL_TIME, $urandom_range(0, 1500));
        write_reg(CFG_DECAY_TIME, $urandom & 16'hFFFF);
        write_reg(CFG_PEAK_LEVEL, $urandom & 8'hFF);
        write_reg(CFG_NOISE_SEED, $urandom);
        end_writes();
    endtask

    // stimulus
    initial
    begin
        rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        cfg_we = 0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed ticks at reset settings
        send_tick(16'd0, 32'd0);
        send_tick(16'hFFFF, 32'hFFFF_FFFF);
        send_tick(16'd0, 32'hFFFF_FFFF);
        send_tick(16'd0, 32'd0);
        send_tick(16'd250, 32'd0);
        send_tick(16'd250, 32'hAAAA_AAAA);
        send_tick(16'hFFFF, 32'h5555_5555);
        send_tick(16'd1, 32'd0);
        send_tick(16'd500, 32'h8000_0001);
        send_tick(16'd0, 32'd0);
        send_tick(16'hFFFF, 32'd0);
        send_tick(16'd0, 32'd0);
        drain();

        // no managed slots
        write_reg(CFG_SLOTS_IN_USE, 32'd0);
        end_writes();
        send_tick(16'hFFFF, 32'd0);
        send_tick(16'd7, 32'hFFFF_FFFF);
        drain();

        // oversized counts, black colour, zero seed, zero rise and dwell times
        write_reg(CFG_SLOTS_IN_USE, 32'd63);
        write_reg(CFG_MAX_LIT, 32'd63);
        write_reg(CFG_PEAK_LEVEL, 32'd0);
        write_reg(CFG_NOISE_SEED, 32'd0);
        write_reg(CFG_RISE_TIME, 32'd0);
        write_reg(CFG_DWELL_TIME, 32'd0);
        write_reg(CFG_DECAY_TIME, 32'hFFFF);
        end_writes();
        send_tick(16'd0, 32'd0);
        send_tick(16'd0, 32'd0);
        send_tick(16'hFFFF, 32'hFFFF_FFFF);
        random_ticks(25);
        drain();

        // single slot, top values but zero decay time
        write_reg(CFG_SLOTS_IN_USE, 32'd1);
        write_reg(CFG_MAX_LIT, 32'd1);
        write_reg(CFG_PEAK_LEVEL, 32'd255);
        write_reg(CFG_NOISE_SEED, 32'hFFFF_FFFF);
        write_reg(CFG_RISE_TIME, 32'hFFFF);
        write_reg(CFG_DWELL_TIME, 32'hFFFF);
        write_reg(CFG_DECAY_TIME, 32'd0);
        end_writes();
        random_ticks(20);
        drain();

        // nothing may start
        write_reg(CFG_SLOTS_IN_USE, 32'd32);
        write_reg(CFG_MAX_LIT, 32'd0);
        end_writes();
        random_ticks(8);
        drain();

        // random settings, one with a long output hold-off
        for (int p = 0; p < 5; p++)
        begin
            random_setting();
            if (p == 2)
                want_holdoff = 1;
            random_ticks(28);
            drain();
        end

        if (ledger.mismatches == 0 && ledger.pending_cmds.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/rlbs_pkg.sv
rtl/rlbs_cell.sv
rtl/rlbs_div.sv
rtl/random_led_breathe_scheduler_core.sv
test/random_led_breathe_scheduler_core_tb.sv
